// File: rtl/core/q4dot_pkg.sv
// ----------------------------------------------------------------------------
// q4dot_pkg
// Shared widths, scale decode constants and the queue entry for the q4
// block dot product.
// ----------------------------------------------------------------------------
package q4dot_pkg;

   localparam int ACT_BITS      = 16;
   localparam int ACC_FRAC_BITS = 32;

   localparam int SCALE_W = 16;
   localparam int BYTE_W  = 8;
   localparam int NIB_W   = 4;
   localparam int DOT_W   = 64;

   // nibble-8 times activation, exact
   localparam int PROD_W = ACT_BITS + NIB_W;
   // per-block sum, wraps at this width
   localparam int BSUM_W = ACT_BITS + 9;

   // fp16 fields
   localparam int EXP_W  = 5;
   localparam int MANT_W = 10;
   localparam int SIG_W  = MANT_W + 1;
   localparam logic [EXP_W-1:0] EXP_SPECIAL = '1;
   localparam logic [EXP_W-1:0] EXP_SUBNORM = '0;

   // shift applied to sum*m is (exp - 1) + SH_MIN, exp - 1 in 0..EXP_SPAN
   localparam int EXP_SPAN = 29;
   localparam int SH_MIN   = 1 - 25 - (ACT_BITS - 4) + ACC_FRAC_BITS;
   localparam int LSH_BASE = (SH_MIN > 0) ? SH_MIN : 0;
   localparam int RSH      = (SH_MIN < 0) ? -SH_MIN : 0;

   // scaled product, shifted word and saturation check widths
   localparam int PW = BSUM_W + SIG_W + 1;
   localparam int WW = PW + EXP_SPAN + LSH_BASE;
   localparam int EW = (WW > DOT_W + 1) ? WW : DOT_W + 1;

   localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
   localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // one classified request as it waits between front and back
   typedef struct packed {
      logic signed [PROD_W-1:0] prod_low;
      logic signed [PROD_W-1:0] prod_high;
      logic                     block_end;
      logic                     row_end;
      logic                     scale_neg;
      logic                     scale_bad;
      logic [SIG_W-1:0]         scale_sig;
      logic [EXP_W-1:0]         scale_exp_m1;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

// File: rtl/core/q4dot_front.sv
// ----------------------------------------------------------------------------
// q4dot_front
// Takes requests, forms the two nibble products and decodes the fp16 block
// scale into sign, significand and exponent for the back end.
// ----------------------------------------------------------------------------
module q4dot_front
   import q4dot_pkg::*;
(
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SCALE_W-1:0]         req_scale_bits,
   input  logic [BYTE_W-1:0]          req_weight_byte,
   input  logic signed [ACT_BITS-1:0] req_act_low,
   input  logic signed [ACT_BITS-1:0] req_act_high,
   input  logic                       req_block_last,
   input  logic                       req_row_last,
   input  logic                       q_full,
   output logic                       q_push,
   output entry_type                  q_entry
);

   logic signed [NIB_W-1:0] nib_low;
   logic signed [NIB_W-1:0] nib_high;
   logic [EXP_W-1:0]        exp_field;
   logic [MANT_W-1:0]       mant_field;
   logic                    subnormal;

   // nibble minus 8 is the nibble with its top bit flipped
   assign nib_low  = $signed({~req_weight_byte[3], req_weight_byte[2:0]});
   assign nib_high = $signed({~req_weight_byte[7], req_weight_byte[6:4]});

   assign exp_field  = req_scale_bits[MANT_W +: EXP_W];
   assign mant_field = req_scale_bits[MANT_W-1:0];
   assign subnormal  = (exp_field == EXP_SUBNORM);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_entry.prod_low     = PROD_W'(nib_low) * PROD_W'(req_act_low);
      q_entry.prod_high    = PROD_W'(nib_high) * PROD_W'(req_act_high);
      q_entry.block_end    = req_block_last || req_row_last;
      q_entry.row_end      = req_row_last;
      q_entry.scale_neg    = req_scale_bits[SCALE_W-1];
      q_entry.scale_bad    = (exp_field == EXP_SPECIAL);
      q_entry.scale_sig    = {!subnormal, mant_field};
      // subnormals use exponent 1
      q_entry.scale_exp_m1 = subnormal ? EXP_SUBNORM : exp_field - EXP_W'(1);
   end

endmodule

// File: rtl/core/q4dot_queue.sv
// ----------------------------------------------------------------------------
// q4dot_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module q4dot_queue
   import q4dot_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_entry,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   entry_type          slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_CNT_W-1:0] count_in;

   assign full       = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/q4dot_back.sv
// ----------------------------------------------------------------------------
// q4dot_back
// Sums products per block; at block end scales the sum, shifts it into the
// accumulator format and adds it with saturation; at row end emits the
// response from an output register.
// ----------------------------------------------------------------------------
module q4dot_back
   import q4dot_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  queue_head_type          head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [DOT_W-1:0] rsp_dot_value,
   output logic                    rsp_overflow,
   output logic                    rsp_bad_scale
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SHIFT,
      ST_ADD
   } state_type;

   state_type               state_ff;
   logic signed [BSUM_W-1:0] bsum_ff;
   logic signed [DOT_W-1:0]  acc_ff;
   logic                     ovf_seen_ff;
   logic                     bad_seen_ff;

   // block end in flight
   logic                     row_ff;
   logic                     neg_ff;
   logic                     bad_ff;
   logic [SIG_W-1:0]         sig_ff;
   logic [EXP_W-1:0]         exp_m1_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [DOT_W-1:0]  contrib_ff;
   logic                     shift_ovf_ff;

   logic                     rsp_valid_ff;
   logic signed [DOT_W-1:0]  rsp_dot_ff;
   logic                     rsp_ovf_ff;
   logic                     rsp_bad_ff;

   logic signed [BSUM_W-1:0] bsum_in;
   logic signed [PW-1:0]     prod_in;
   logic signed [WW-1:0]     shifted;
   logic signed [EW-1:0]     shifted_ext;
   logic                     fits;
   logic signed [DOT_W-1:0]  contrib_in;
   logic                     shift_ovf_in;
   logic signed [DOT_W:0]    acc_sum;
   logic signed [DOT_W-1:0]  acc_in;
   logic                     ovf_in;
   logic                     bad_in;
   logic                     out_free;

   assign pop      = (state_ff == ST_IDLE) && head.valid;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dot_value = rsp_dot_ff;
   assign rsp_overflow  = rsp_ovf_ff;
   assign rsp_bad_scale = rsp_bad_ff;

   always_comb begin
      bsum_in = bsum_ff + BSUM_W'(head.entry.prod_low) + BSUM_W'(head.entry.prod_high);

      prod_in = PW'(bsum_ff) * PW'($signed({1'b0, sig_ff}));

      // left shift then fixed right shift gives a floor for negative shifts
      shifted     = (WW'(prod_ff) <<< (int'(exp_m1_ff) + LSH_BASE)) >>> RSH;
      shifted_ext = EW'(shifted);
      fits        = (&shifted_ext[EW-1:DOT_W-1]) || !(|shifted_ext[EW-1:DOT_W-1]);
      if (bad_ff) begin
         contrib_in   = '0;
         shift_ovf_in = 1'b0;
      end else if (fits) begin
         contrib_in   = shifted_ext[DOT_W-1:0];
         shift_ovf_in = 1'b0;
      end else begin
         contrib_in   = shifted_ext[EW-1] ? DOT_MIN : DOT_MAX;
         shift_ovf_in = 1'b1;
      end

      acc_sum = (DOT_W+1)'(acc_ff) + (DOT_W+1)'(contrib_ff);
      ovf_in  = ovf_seen_ff || shift_ovf_ff;
      if (acc_sum[DOT_W] != acc_sum[DOT_W-1]) begin
         acc_in = acc_sum[DOT_W] ? DOT_MIN : DOT_MAX;
         ovf_in = 1'b1;
      end else begin
         acc_in = acc_sum[DOT_W-1:0];
      end
      bad_in = bad_seen_ff || bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bsum_ff      <= '0;
         acc_ff       <= '0;
         ovf_seen_ff  <= 1'b0;
         bad_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a row end in the add state reloads the register below
         if (rsp_valid_ff && rsp_ready && !(state_ff == ST_ADD && row_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (head.valid) begin
                  bsum_ff <= bsum_in;
                  if (head.entry.block_end) begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               bsum_ff  <= '0;
               state_ff <= ST_SHIFT;
            end
            ST_SHIFT: begin
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               if (!row_ff) begin
                  acc_ff      <= acc_in;
                  ovf_seen_ff <= ovf_in;
                  bad_seen_ff <= bad_in;
                  state_ff    <= ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  acc_ff       <= '0;
                  ovf_seen_ff  <= 1'b0;
                  bad_seen_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (pop) begin
         row_ff    <= head.entry.row_end;
         neg_ff    <= head.entry.scale_neg;
         bad_ff    <= head.entry.scale_bad;
         sig_ff    <= head.entry.scale_sig;
         exp_m1_ff <= head.entry.scale_exp_m1;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= neg_ff ? -prod_in : prod_in;
      end
      if (state_ff == ST_SHIFT) begin
         contrib_ff   <= contrib_in;
         shift_ovf_ff <= shift_ovf_in;
      end
      if (state_ff == ST_ADD && row_ff && out_free) begin
         rsp_dot_ff <= acc_in;
         rsp_ovf_ff <= ovf_in;
         rsp_bad_ff <= bad_in;
      end
   end

endmodule

// File: rtl/core/q4_block_dot_product.sv
// ----------------------------------------------------------------------------
// q4_block_dot_product
// A row-end response is registered in the add state, after the idle, multiply
// and shift states. Throughput: one request per cycle in a block unless the
// queue is full; while a block-end request holds the back end in multiply,
// shift and saturating add, a 2-entry queue lets requests keep arriving.
// Reset (synchronous) clears the block sum, accumulator, flags and queue.
// ----------------------------------------------------------------------------
module q4_block_dot_product
   import q4dot_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SCALE_W-1:0]         req_scale_bits,
   input  logic [BYTE_W-1:0]          req_weight_byte,
   input  logic signed [ACT_BITS-1:0] req_act_low,
   input  logic signed [ACT_BITS-1:0] req_act_high,
   input  logic                       req_block_last,
   input  logic                       req_row_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DOT_W-1:0]    rsp_dot_value,
   output logic                       rsp_overflow,
   output logic                       rsp_bad_scale
);

   logic           q_full;
   logic           q_push;
   logic           q_pop;
   entry_type      q_entry;
   queue_head_type q_head;

   q4dot_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_scale_bits  (req_scale_bits),
      .req_weight_byte (req_weight_byte),
      .req_act_low     (req_act_low),
      .req_act_high    (req_act_high),
      .req_block_last  (req_block_last),
      .req_row_last    (req_row_last),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   q4dot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head)
   );

   q4dot_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dot_value (rsp_dot_value),
      .rsp_overflow  (rsp_overflow),
      .rsp_bad_scale (rsp_bad_scale)
   );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the q4 block dot product. A short table of directed
// requests (fp16 extremes, infinity and NaN scales, zero and subnormal scales,
// split blocks) is followed by random rows: normal rows, overlong blocks that
// wrap the block sum, heavy rows that can saturate the accumulator and loose
// requests with random markers. Every accepted request goes through a local
// bit-exact model, and each response is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import q4dot_pkg::*;

   localparam int RANDOM_TARGET = 1850;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HEAVY_BLOCKS  = 20;
   localparam int FP16_BIAS     = 15;
   localparam int NIB_ZERO      = 8;

   localparam logic [ACT_BITS-1:0] ACT_MIN = {1'b1, {(ACT_BITS-1){1'b0}}};
   localparam logic [ACT_BITS-1:0] ACT_MAX = {1'b0, {(ACT_BITS-1){1'b1}}};
   localparam logic [EXP_W-1:0]    EXP_TOP = EXP_SPECIAL - 1'b1;

   typedef struct packed {
      logic [SCALE_W-1:0]  scale_bits;
      logic [BYTE_W-1:0]   weight_byte;
      logic [ACT_BITS-1:0] act_low;
      logic [ACT_BITS-1:0] act_high;
      logic                block_last;
      logic                row_last;
   } q4_req_type;

   typedef struct packed {
      logic [DOT_W-1:0] dot;
      logic             ovf;
      logic             bad;
   } dot_result_type;

   // known = 1: response is typed in by hand instead of taken from the model
   typedef struct packed {
      q4_req_type     r;
      logic           known;
      dot_result_type res;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [SCALE_W-1:0]         req_scale_bits = '0;
   logic [BYTE_W-1:0]          req_weight_byte = '0;
   logic signed [ACT_BITS-1:0] req_act_low = '0;
   logic signed [ACT_BITS-1:0] req_act_high = '0;
   logic                       req_block_last = 1'b0;
   logic                       req_row_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DOT_W-1:0]    rsp_dot_value;
   logic                       rsp_overflow;
   logic                       rsp_bad_scale;

   q4_block_dot_product DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_scale_bits  (req_scale_bits),
      .req_weight_byte (req_weight_byte),
      .req_act_low     (req_act_low),
      .req_act_high    (req_act_high),
      .req_block_last  (req_block_last),
      .req_row_last    (req_row_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dot_value   (rsp_dot_value),
      .rsp_overflow    (rsp_overflow),
      .rsp_bad_scale   (rsp_bad_scale)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   logic signed [BSUM_W-1:0] blk_sum = '0;
   logic signed [DOT_W-1:0]  row_dot = '0;
   logic                     row_ovf = 1'b0;
   logic                     row_bad = 1'b0;
   dot_result_type           dot_expect[$];

   function automatic logic signed [DOT_W-1:0] scale_shift(input longint p, input int sh);
      longint lim;
      if (sh >= 0) begin
         if (p == 0) return '0;
         if (sh > 62) begin
            row_ovf = 1'b1;
            return (p > 0) ? DOT_MAX : DOT_MIN;
         end
         lim = DOT_MAX >>> sh;
         if (p > lim) begin
            row_ovf = 1'b1;
            return DOT_MAX;
         end
         if (p < -lim - 1) begin
            row_ovf = 1'b1;
            return DOT_MIN;
         end
         return p <<< sh;
      end
      // arithmetic shift, rounds toward minus infinity
      if (-sh >= 63) return (p < 0) ? -64'sd1 : 64'sd0;
      return p >>> (-sh);
   endfunction

   function automatic logic signed [DOT_W-1:0] sat_add(input logic signed [DOT_W-1:0] a,
                                                        input logic signed [DOT_W-1:0] b);
      logic signed [DOT_W:0] s;
      s = $signed({a[DOT_W-1], a}) + $signed({b[DOT_W-1], b});
      if (s > DOT_MAX) begin
         row_ovf = 1'b1;
         return DOT_MAX;
      end
      if (s < DOT_MIN) begin
         row_ovf = 1'b1;
         return DOT_MIN;
      end
      return s[DOT_W-1:0];
   endfunction

   // folds one request into the row state, returns 1 on a row end
   function automatic bit dot_fold(input q4_req_type r, output dot_result_type res);
      longint           lo, hi, p, sig;
      int               ex, sh;
      logic [EXP_W-1:0] ef;
      res = '0;
      lo = longint'(r.weight_byte[NIB_W-1:0]) - NIB_ZERO;
      hi = longint'(r.weight_byte[BYTE_W-1:NIB_W]) - NIB_ZERO;
      p  = longint'(blk_sum) + lo * longint'($signed(r.act_low))
         + hi * longint'($signed(r.act_high));
      blk_sum = p[BSUM_W-1:0];
      if (r.block_last || r.row_last) begin
         ef = r.scale_bits[SCALE_W-2 -: EXP_W];
         if (ef == EXP_SPECIAL) begin
            row_bad = 1'b1;
         end else begin
            ex  = int'(ef);
            sig = longint'(r.scale_bits[MANT_W-1:0]);
            if (ef == EXP_SUBNORM) ex = 1;
            else sig = sig + (longint'(1) << MANT_W);
            p = longint'(blk_sum) * sig;
            if (r.scale_bits[SCALE_W-1]) p = -p;
            sh = ex - FP16_BIAS - MANT_W - (ACT_BITS - 4) + ACC_FRAC_BITS;
            row_dot = sat_add(row_dot, scale_shift(p, sh));
         end
         blk_sum = '0;
      end
      if (r.row_last) begin
         res.dot = row_dot;
         res.ovf = row_ovf;
         res.bad = row_bad;
         row_dot = '0;
         row_ovf = 1'b0;
         row_bad = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // -------------------------------------------------------------- monitor
   stim_row_type typed_row = '0;
   int           err_count = 0;
   int           req_seen = 0;
   int           rsp_taken = 0;
   int           sat_rows = 0;
   int           bad_rows = 0;

   always @(posedge clock) begin : monitor
      q4_req_type     got;
      dot_result_type pred;
      dot_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            got.scale_bits  = req_scale_bits;
            got.weight_byte = req_weight_byte;
            got.act_low     = req_act_low;
            got.act_high    = req_act_high;
            got.block_last  = req_block_last;
            got.row_last    = req_row_last;
            req_seen++;
            if (dot_fold(got, pred))
               dot_expect.push_back(typed_row.known ? typed_row.res : pred);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken++;
            if (dot_expect.size() == 0) begin
               $error("response with nothing expected: dot_value %0d", rsp_dot_value);
               err_count++;
            end else begin
               want = dot_expect.pop_front();
               if (rsp_dot_value !== want.dot) begin
                  $error("dot_value mismatch: expected %0d, got %0d",
                         $signed(want.dot), rsp_dot_value);
                  err_count++;
               end
               if (rsp_overflow !== want.ovf) begin
                  $error("overflow mismatch: expected %0b, got %0b", want.ovf, rsp_overflow);
                  err_count++;
               end
               if (rsp_bad_scale !== want.bad) begin
                  $error("bad_scale mismatch: expected %0b, got %0b", want.bad, rsp_bad_scale);
                  err_count++;
               end
               if (want.ovf) sat_rows++;
               if (want.bad) bad_rows++;
            end
         end
      end
   end

   // ------------------------------------------------------------- receiver
   bit quiet = 1'b0;
   bit hold_trigger = 1'b0;
   bit hold_started = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int rsp_counted = 0;

   always @(negedge clock) begin
      if (hold_trigger && !hold_started) begin
         hold_started = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (rsp_taken != rsp_counted) begin
         rsp_counted = rsp_taken;
         stall_left = quiet ? 0 : $urandom_range(0, 4);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------- sender
   stim_row_type dir_rows[$];

   function automatic void dir_add(input logic [SCALE_W-1:0] scale, input logic [BYTE_W-1:0] wb,
                                   input logic [ACT_BITS-1:0] al, input logic [ACT_BITS-1:0] ah,
                                   input logic bl, input logic rl, input logic known,
                                   input logic [DOT_W-1:0] dot, input logic ovf,
                                   input logic bad);
      stim_row_type t;
      t.r   = '{scale, wb, al, ah, bl, rl};
      t.known = known;
      t.res = '{dot, ovf, bad};
      dir_rows.push_back(t);
   endfunction

   function automatic logic [ACT_BITS-1:0] pick_act();
      case ($urandom_range(0, 7))
         0: return ACT_MIN;
         1: return ACT_MAX;
         2: return '0;
         3: return '1;
         default: return ACT_BITS'($urandom_range(0, (1 << ACT_BITS) - 1));
      endcase
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale();
      logic [MANT_W-1:0] mant;
      logic [EXP_W-1:0]  ef;
      mant = MANT_W'($urandom_range(0, (1 << MANT_W) - 1));
      case ($urandom_range(0, 9))
         0: ef = EXP_SPECIAL;
         1: ef = EXP_SUBNORM;
         2: return SCALE_W'($urandom_range(0, (1 << SCALE_W) - 1));
         default: ef = EXP_W'($urandom_range(8, 22));
      endcase
      return {1'($urandom_range(0, 1)), ef, mant};
   endfunction

   task automatic send_req(input stim_row_type t);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_scale_bits  <= t.r.scale_bits;
      req_weight_byte <= t.r.weight_byte;
      req_act_low     <= t.r.act_low;
      req_act_high    <= t.r.act_high;
      req_block_last  <= t.r.block_last;
      req_row_last    <= t.r.row_last;
      typed_row       <= t;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // big_odds out of 8 requests carry the largest products of one sign
   task automatic send_block(input int len, input int big_odds, input bit heavy, input bit neg,
                             input bit blk_flag, input bit row_flag);
      stim_row_type t;
      bit           big;
      t = '0;
      for (int i = 0; i < len; i++) begin
         big = heavy || ($urandom_range(0, 7) < big_odds);
         t.r.weight_byte = big ? 8'h00 : 8'($urandom_range(0, 255));
         t.r.act_low     = big ? ACT_MIN : pick_act();
         t.r.act_high    = big ? ACT_MIN : pick_act();
         t.r.scale_bits  = heavy ? {neg, EXP_TOP, 10'($urandom_range(0, 1023))} : pick_scale();
         t.r.block_last  = (i == len - 1) ? blk_flag : 1'b0;
         t.r.row_last    = (i == len - 1) ? row_flag : 1'b0;
         send_req(t);
      end
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(negedge clock); while (dot_expect.size() != 0);
   endtask

   initial begin
      int  row_idx;
      int  nblk;
      int  heavy_rows;
      bit  last_blk;
      // after reset and extremes
      dir_add(16'h3C00, 8'h88, ACT_MAX, ACT_MIN, 0, 1, 1, 64'h0, 0, 0);
      dir_add(16'h3C00, 8'h00, ACT_MIN, ACT_MIN, 0, 1, 1, 64'h0000_0080_0000_0000, 0, 0);
      // infinity and NaN scales add nothing and raise bad_scale
      dir_add(16'h7C00, 8'hFF, ACT_MAX, ACT_MAX, 1, 1, 1, 64'h0, 0, 1);
      dir_add(16'hFE00, 8'h5A, 16'h1234, ACT_MIN, 0, 1, 1, 64'h0, 0, 1);
      // positive and negative zero scales
      dir_add(16'h0000, 8'h00, ACT_MIN, ACT_MIN, 0, 1, 1, 64'h0, 0, 0);
      dir_add(16'h8000, 8'hFF, ACT_MAX, ACT_MAX, 0, 1, 1, 64'h0, 0, 0);
      // several blocks in one row, smallest subnormal and normal, largest normal
      dir_add(16'h0001, 8'h0F, ACT_MAX, ACT_MAX, 1, 0, 0, 64'h0, 0, 0);
      dir_add(16'h8400, 8'hF0, ACT_MAX, ACT_MAX, 1, 0, 0, 64'h0, 0, 0);
      dir_add(16'h7BFF, 8'h00, ACT_MIN, ACT_MIN, 0, 0, 0, 64'h0, 0, 0);
      dir_add(16'h7BFF, 8'hFF, ACT_MIN, ACT_MIN, 1, 0, 0, 64'h0, 0, 0);
      dir_add(16'hFBFF, 8'h00, ACT_MIN, ACT_MAX, 0, 1, 0, 64'h0, 0, 0);
      dir_add(16'h03FF, 8'h11, 16'h4000, 16'hC000, 0, 1, 0, 64'h0, 0, 0);
      // requests with no marker continue the block
      dir_add(16'h3555, 8'h0F, ACT_MIN, 16'h0001, 0, 0, 0, 64'h0, 0, 0);
      dir_add(16'h3555, 8'hF0, 16'hFFFF, ACT_MIN, 0, 0, 0, 64'h0, 0, 0);
      // NaN block in the middle of a row, later blocks still count
      dir_add(16'h7E01, 8'h00, ACT_MIN, ACT_MIN, 1, 0, 0, 64'h0, 0, 0);
      dir_add(16'h4000, 8'h88, 16'h0000, 16'h0000, 0, 0, 0, 64'h0, 0, 0);
      dir_add(16'h4000, 8'h37, 16'h7001, 16'h8FFF, 0, 1, 0, 64'h0, 0, 0);
      dir_add(16'h0400, 8'hA5, 16'h0001, 16'hFFFF, 1, 1, 0, 64'h0, 0, 0);
      // negative subnormal shifts right with rounding down
      dir_add(16'h8001, 8'h00, ACT_MIN, ACT_MIN, 0, 1, 0, 64'h0, 0, 0);
      dir_add(16'h8003, 8'hFF, 16'h0001, 16'h0003, 0, 1, 0, 64'h0, 0, 0);
      dir_add(16'h13FF, 8'h7F, 16'h5555, 16'hAAAA, 1, 1, 0, 64'h0, 0, 0);

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_req(dir_rows[i]);

      row_idx = 0;
      heavy_rows = 0;
      while (req_seen < RANDOM_TARGET) begin
         quiet = ($urandom_range(0, 7) == 0);
         if (row_idx == 8) hold_trigger = 1'b1;
         if (row_idx == 16) drain_wait();
         if (row_idx % 24 == 3) begin
            // every block at full magnitude, one sign: can saturate the row
            for (int b = 0; b < HEAVY_BLOCKS; b++)
               send_block(16, 8, 1'b1, heavy_rows[0], 1'b1, b == HEAVY_BLOCKS - 1);
            heavy_rows++;
         end else if ($urandom_range(0, 9) == 0) begin
            // loose requests with random markers
            repeat ($urandom_range(1, 6))
               send_block(1, 0, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
         end else begin
            nblk = $urandom_range(1, 3);
            for (int b = 0; b < nblk; b++) begin
               last_blk = (b == nblk - 1);
               if ($urandom_range(0, 11) == 0)
                  send_block($urandom_range(33, 48), 7, 1'b0, 1'b0, 1'b1, last_blk);
               else
                  send_block($urandom_range(0, 1) ? 16 : $urandom_range(1, 16), 0, 1'b0, 1'b0,
                             !last_blk || 1'($urandom_range(0, 1)), last_blk);
            end
         end
         row_idx++;
      end

      quiet = 1'b0;
      drain_wait();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run covered %0d requests and %0d responses, %0d rows saturated, %0d bad scale",
               req_seen, rsp_taken, sat_rows, bad_rows);
      $display("directed scale extremes, then random rows, overlong blocks and both-side stalls");
      if (err_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // ends the run as failed if it has not finished within this time limit
   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
